### rtl/segmented_prime_sieve_assert.svh
// Assertion macros for the segmented prime sieve.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SEGMENTED_PRIME_SIEVE_ASSERT_SVH
`define SEGMENTED_PRIME_SIEVE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define SPS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SPS_ASSERT_NOW(lbl, cond, msg)
`define SPS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/sps_pkg.sv
// Shared constants and types of the segmented prime sieve.
// No dependencies.
`default_nettype none
package sps_pkg;
  localparam int unsigned PRIME_W = 30;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BASE_LIMIT_DEF = 32768;
  localparam int unsigned SEGMENT_SPAN_DEF = 131072;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;

  typedef struct packed {
    logic [PRIME_W-1:0] prime_value;
    logic               last_prime;
    logic               exhausted;
    logic               range_error;
  } res_t;
endpackage
`default_nettype wire

### rtl/segmented_prime_sieve.sv
// Segmented prime sieve: one request in, one result out.
// A fetch scans bitmap entries one by one, past the prime found on to the next one.
// First fetch after restart/config also clears span entries, then per small prime
// runs the remainder unit and marks each multiple: segment RAM port bound.
// Reset: the small-prime table is cleared and rebuilt, each multiple marked in turn;
// no request is taken until it is done.
`default_nettype none
module segmented_prime_sieve #(
  parameter int unsigned BASE_LIMIT   = sps_pkg::BASE_LIMIT_DEF,
  parameter int unsigned SEGMENT_SPAN = sps_pkg::SEGMENT_SPAN_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [7:0]                     s_axis_tdata_i,  // [0] restart
  // result stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [31:0]                         m_axis_tdata_o,  // [29:0] prime_value
  output logic                                m_axis_tlast_o,  // last_prime
  output logic [1:0]                          m_axis_tuser_o   // [0] exhausted, [1] range_error
);
  localparam int unsigned SAW = $clog2(BASE_LIMIT);
  localparam int unsigned AW  = $clog2(SEGMENT_SPAN);

  logic [sps_pkg::PRIME_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic                        cfg_wr, cfg_clear;
  logic                        out_valid_q, out_valid_d, out_free;
  sps_pkg::res_t               out_q, out_d, res;
  logic                        res_valid, req_ready;

  logic           sm_we, sm_wdata, sm_rdata;
  logic [SAW-1:0] sm_waddr, sm_raddr;
  logic           seg_we, seg_wdata, seg_rdata;
  logic [AW-1:0]  seg_waddr, seg_raddr;

  // Configuration is always taken; only indexes of real registers re-arm the sieve.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_clear   = cfg_wr && ((cfg_index_i == sps_pkg::REG_RANGE_LOW) ||
                                  (cfg_index_i == sps_pkg::REG_RANGE_HIGH));

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cfg_wr) begin
      case (cfg_index_i)
        sps_pkg::REG_RANGE_LOW:  lo_d = cfg_data_i[sps_pkg::PRIME_W-1:0];
        sps_pkg::REG_RANGE_HIGH: hi_d = cfg_data_i[sps_pkg::PRIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: the sequencer hands a result over once the slot is free or
  // drains this cycle, so the next request is taken while a result waits.
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q        <= sps_pkg::PRIME_W'(1);
      hi_q        <= sps_pkg::PRIME_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Small-prime table and segment bitmap. Writes and reads of each RAM fall in
  // separate phases of the sequencer, so no forwarding is needed.
  sps_bit_ram #(.DEPTH(BASE_LIMIT)) u_small_ram (
    .clk_i, .we_i(sm_we), .waddr_i(sm_waddr), .wdata_i(sm_wdata),
    .raddr_i(sm_raddr), .rdata_o(sm_rdata)
  );

  sps_bit_ram #(.DEPTH(SEGMENT_SPAN)) u_seg_ram (
    .clk_i, .we_i(seg_we), .waddr_i(seg_waddr), .wdata_i(seg_wdata),
    .raddr_i(seg_raddr), .rdata_o(seg_rdata)
  );

  sps_ctrl #(.BASE_LIMIT(BASE_LIMIT), .SEGMENT_SPAN(SEGMENT_SPAN)) u_ctrl (
    .clk_i, .rst_ni,
    .lo_i(lo_q), .hi_i(hi_q), .cfg_clear_i(cfg_clear),
    .req_valid_i(s_axis_tvalid_i), .req_restart_i(s_axis_tdata_i[0]),
    .req_ready_o(req_ready),
    .res_valid_o(res_valid), .res_free_i(out_free), .res_o(res),
    .sm_we_o(sm_we), .sm_waddr_o(sm_waddr), .sm_wdata_o(sm_wdata),
    .sm_raddr_o(sm_raddr), .sm_rdata_i(sm_rdata),
    .seg_we_o(seg_we), .seg_waddr_o(seg_waddr), .seg_wdata_o(seg_wdata),
    .seg_raddr_o(seg_raddr), .seg_rdata_i(seg_rdata)
  );

  assign s_axis_tready_o = req_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.prime_value};
  assign m_axis_tlast_o  = out_q.last_prime;
  assign m_axis_tuser_o  = {out_q.range_error, out_q.exhausted};

`include "segmented_prime_sieve_assert.svh"

  // an exhausted result carries no prime
  `SPS_ASSERT_NOW(a_exh_zero, !(m_axis_tvalid_o && m_axis_tuser_o[0]) || (m_axis_tdata_o == 32'd0), "exhausted result with a prime")
  // a last prime is never also exhausted
  `SPS_ASSERT_NOW(a_last_excl, !(m_axis_tvalid_o && m_axis_tlast_o) || !m_axis_tuser_o[0], "last and exhausted together")
  // one request at a time: the sequencer leaves idle after taking one
  `SPS_ASSERT_NEXT(a_one_req, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "request taken twice in a row")
endmodule
`default_nettype wire

### rtl/sps_bit_ram.sv
// One-bit-wide synchronous RAM, one write and one read port, read data registered.
// No dependencies.
`default_nettype none
module sps_bit_ram #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic                     wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic                          rdata_o
);
  logic mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/sps_mod_unit.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on sps_pkg.
`default_nettype none
module sps_mod_unit #(
  parameter int unsigned PW = 17
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [sps_pkg::PRIME_W-1:0] dividend_i,
  input  wire logic [PW-1:0]               divisor_i,
  output logic                             done_o,
  output logic [PW-1:0]                    rem_o
);
  localparam int unsigned CW = $clog2(sps_pkg::PRIME_W + 1);

  logic                        busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [PW-1:0]               rem_q, rem_d;
  logic [sps_pkg::PRIME_W-1:0] dvd_q, dvd_d;
  logic [PW:0]                 trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    trial  = {rem_q, dvd_q[sps_pkg::PRIME_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(sps_pkg::PRIME_W);
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
      end
      rem_d = trial[PW-1:0];
      dvd_d = {dvd_q[sps_pkg::PRIME_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### rtl/sps_ctrl.sv
// Sequencer of the sieve: builds the small-prime table, sieves the segment, scans it.
// Depends on sps_pkg and sps_mod_unit; drives the two bit RAMs held by the top level.
`default_nettype none
module sps_ctrl #(
  parameter int unsigned BASE_LIMIT   = sps_pkg::BASE_LIMIT_DEF,
  parameter int unsigned SEGMENT_SPAN = sps_pkg::SEGMENT_SPAN_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [sps_pkg::PRIME_W-1:0] lo_i,
  input  wire logic [sps_pkg::PRIME_W-1:0] hi_i,
  input  wire logic                        cfg_clear_i,
  input  wire logic                        req_valid_i,
  input  wire logic                        req_restart_i,
  output logic                             req_ready_o,
  output logic                             res_valid_o,
  input  wire logic                        res_free_i,
  output sps_pkg::res_t                    res_o,
  output logic                             sm_we_o,
  output logic [$clog2(BASE_LIMIT)-1:0]    sm_waddr_o,
  output logic                             sm_wdata_o,
  output logic [$clog2(BASE_LIMIT)-1:0]    sm_raddr_o,
  input  wire logic                        sm_rdata_i,
  output logic                             seg_we_o,
  output logic [$clog2(SEGMENT_SPAN)-1:0]  seg_waddr_o,
  output logic                             seg_wdata_o,
  output logic [$clog2(SEGMENT_SPAN)-1:0]  seg_raddr_o,
  input  wire logic                        seg_rdata_i
);
  localparam int unsigned SAW = $clog2(BASE_LIMIT);
  localparam int unsigned AW  = $clog2(SEGMENT_SPAN);
  localparam int unsigned PW  = SAW + 1;
  localparam int unsigned PW2 = 2 * PW;
  localparam int unsigned JW  = ((PW2 > 31) ? PW2 : 31) + 1;
  localparam int unsigned NW  = sps_pkg::PRIME_W + 1;

  typedef enum logic [3:0] {
    S_BCLR, S_BRD, S_BCHK, S_BMARK, S_IDLE, S_SCLR, S_SRD, S_SCHK,
    S_SMOD, S_SMARK, S_FIND, S_FCHK, S_RES
  } state_e;

  state_e        state_q, state_d;
  logic [PW-1:0] p_q, p_d;
  logic [PW2-1:0] sq_q, sq_d;
  logic [JW-1:0] j_q, j_d;
  logic [AW:0]   off_q, off_d, cursor_q, cursor_d;
  logic [AW-1:0] found_q, found_d;
  logic          ready_q, ready_d, phase_q, phase_d;
  sps_pkg::res_t res_q, res_d;

  logic [NW-1:0] span_full;
  logic [AW:0]   span;
  logic          bad;
  logic          mod_start, mod_done;
  logic [PW-1:0] mod_rem, gap;
  logic [JW-1:0] first, sq_j, hi_j, lo_j, prime_j;

  assign span_full = {1'b0, hi_i} - {1'b0, lo_i} + NW'(1);
  assign bad       = (hi_i < lo_i) || (span_full > NW'(SEGMENT_SPAN));
  assign span      = span_full[AW:0];
  assign hi_j      = JW'(hi_i);
  assign lo_j      = JW'(lo_i);
  assign sq_j      = JW'(sq_q);
  assign gap       = (mod_rem == '0) ? '0 : p_q - mod_rem;
  assign first     = lo_j + JW'(gap);
  assign prime_j   = lo_j + JW'(found_q);

  sps_mod_unit #(.PW(PW)) u_mod (
    .clk_i, .rst_ni,
    .start_i(mod_start), .dividend_i(lo_i), .divisor_i(p_q),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  always_comb begin
    state_d  = state_q;
    p_d      = p_q;
    sq_d     = PW2'(p_q) * PW2'(p_q);
    j_d      = j_q;
    off_d    = off_q;
    cursor_d = cursor_q;
    found_d  = found_q;
    ready_d  = ready_q;
    phase_d  = phase_q;
    res_d    = res_q;
    sm_we_o     = 1'b0;
    sm_waddr_o  = j_q[SAW-1:0];
    sm_wdata_o  = 1'b1;
    sm_raddr_o  = p_q[SAW-1:0];
    seg_we_o    = 1'b0;
    seg_waddr_o = j_q[AW-1:0];
    seg_wdata_o = 1'b1;
    seg_raddr_o = off_q[AW-1:0];
    mod_start   = 1'b0;
    req_ready_o = (state_q == S_IDLE);
    res_valid_o = (state_q == S_RES);

    unique case (state_q)
      S_BCLR: begin
        // 0 and 1 are marked composite, all else cleared
        sm_we_o    = 1'b1;
        sm_wdata_o = (j_q < JW'(2));
        if (j_q == JW'(BASE_LIMIT - 1)) begin
          p_d     = PW'(2);
          state_d = S_BRD;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_BRD: state_d = S_BCHK;
      S_BCHK: begin
        if (sq_q >= PW2'(BASE_LIMIT)) begin
          state_d = S_IDLE;
        end else if (sm_rdata_i) begin
          p_d     = p_q + 1'b1;
          state_d = S_BRD;
        end else begin
          j_d     = sq_j;
          state_d = S_BMARK;
        end
      end
      S_BMARK: begin
        if (j_q < JW'(BASE_LIMIT)) begin
          sm_we_o = 1'b1;
          j_d     = j_q + JW'(p_q);
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_BRD;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_restart_i) begin
            cursor_d = '0;
            ready_d  = 1'b0;
            res_d    = '{prime_value: '0, last_prime: 1'b0, exhausted: 1'b0,
                         range_error: bad};
            state_d  = S_RES;
          end else if (bad) begin
            res_d   = '{prime_value: '0, last_prime: 1'b0, exhausted: 1'b1,
                        range_error: 1'b1};
            state_d = S_RES;
          end else if (!ready_q) begin
            j_d     = '0;
            state_d = S_SCLR;
          end else begin
            off_d   = cursor_q;
            phase_d = 1'b0;
            state_d = S_FIND;
          end
        end
      end
      S_SCLR: begin
        seg_we_o    = 1'b1;
        seg_wdata_o = 1'b0;
        if (j_q == JW'(span) - JW'(1)) begin
          p_d     = PW'(2);
          state_d = S_SRD;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_SRD: begin
        if (p_q == PW'(BASE_LIMIT)) begin
          ready_d  = 1'b1;
          cursor_d = '0;
          off_d    = '0;
          phase_d  = 1'b0;
          state_d  = S_FIND;
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sq_q > PW2'(hi_i)) begin
          ready_d  = 1'b1;
          cursor_d = '0;
          off_d    = '0;
          phase_d  = 1'b0;
          state_d  = S_FIND;
        end else if (sm_rdata_i) begin
          p_d     = p_q + 1'b1;
          state_d = S_SRD;
        end else begin
          mod_start = 1'b1;
          state_d   = S_SMOD;
        end
      end
      S_SMOD: begin
        if (mod_done) begin
          j_d     = (first < sq_j) ? sq_j : first;
          state_d = S_SMARK;
        end
      end
      S_SMARK: begin
        seg_waddr_o = AW'(j_q - lo_j);
        if (j_q <= hi_j) begin
          seg_we_o = 1'b1;
          j_d      = j_q + JW'(p_q);
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_FIND: begin
        if (off_q >= span) begin
          if (!phase_q) begin
            cursor_d = span;
            res_d    = '{prime_value: '0, last_prime: 1'b0, exhausted: 1'b1,
                         range_error: 1'b0};
          end else begin
            res_d = '{prime_value: prime_j[sps_pkg::PRIME_W-1:0], last_prime: 1'b1,
                      exhausted: 1'b0, range_error: 1'b0};
          end
          state_d = S_RES;
        end else begin
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!seg_rdata_i && (lo_j + JW'(off_q) >= JW'(2))) begin
          if (!phase_q) begin
            found_d  = off_q[AW-1:0];
            cursor_d = off_q + 1'b1;
            off_d    = off_q + 1'b1;
            phase_d  = 1'b1;
            state_d  = S_FIND;
          end else begin
            res_d   = '{prime_value: prime_j[sps_pkg::PRIME_W-1:0], last_prime: 1'b0,
                        exhausted: 1'b0, range_error: 1'b0};
            state_d = S_RES;
          end
        end else begin
          off_d   = off_q + 1'b1;
          state_d = S_FIND;
        end
      end
      S_RES: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_BCLR;
    endcase

    if (cfg_clear_i) begin
      ready_d  = 1'b0;
      cursor_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_BCLR;
      j_q      <= '0;
      cursor_q <= '0;
      ready_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      j_q      <= j_d;
      cursor_q <= cursor_d;
      ready_q  <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    sq_q    <= sq_d;
    off_q   <= off_d;
    found_q <= found_d;
    phase_q <= phase_d;
    res_q   <= res_d;
  end

  assign res_o = res_q;
endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking bench for segmented_prime_sieve: drives requests and range writes,
// predicts each result in-house or takes one typed in the directed table, and compares field by field.
// Depends on sps_pkg and the segmented_prime_sieve top level.
`default_nettype none
module tb_top;
  localparam int unsigned BASE = sps_pkg::BASE_LIMIT_DEF;
  localparam int unsigned SPAN = sps_pkg::SEGMENT_SPAN_DEF;
  // The slowest silent stretch is a full-span sieve (clear plus marking).
  localparam int unsigned IDLE_LIMIT = 2000000;
  localparam int unsigned ITEM_TARGET = 1500;

  // Request codes carried in tdata[0]
  localparam bit REQ_FETCH   = 1'b0;
  localparam bit REQ_RESTART = 1'b1;
  // Indexes that the block ignores
  localparam logic [sps_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [sps_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [sps_pkg::CFG_IDX_W-1:0]  idx;
    logic [sps_pkg::CFG_DATA_W-1:0] data;   // register value, or the restart code in bit 0
    logic                           typed;  // expected result typed in below
    sps_pkg::res_t                  res;
  } row_t;

  localparam sps_pkg::res_t R_NONE   = '{prime_value: '0, last_prime: 1'b0, exhausted: 1'b1,
                                         range_error: 1'b0};
  localparam sps_pkg::res_t R_REWIND = '{prime_value: '0, last_prime: 1'b0, exhausted: 1'b0,
                                         range_error: 1'b0};
  localparam sps_pkg::res_t R_BAD    = '{prime_value: '0, last_prime: 1'b0, exhausted: 1'b1,
                                         range_error: 1'b1};
  localparam sps_pkg::res_t R_BAD_RW = '{prime_value: '0, last_prime: 1'b0, exhausted: 1'b0,
                                         range_error: 1'b1};

  localparam int unsigned N_ROWS = 32;
  localparam row_t DIRECTED [N_ROWS] = '{
    // range 1..1 after reset holds no prime
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b1, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b1, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_RESTART), 1'b1, R_REWIND},
    // 0..30: zero and one skipped, primes walked, then rewound
    '{ROW_CFG, sps_pkg::REG_RANGE_LOW, 32'd0, 1'b0, R_NONE},
    '{ROW_CFG, sps_pkg::REG_RANGE_HIGH, 32'd30, 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_RESTART), 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    // 0..1 only
    '{ROW_CFG, sps_pkg::REG_RANGE_HIGH, 32'd1, 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b1, R_NONE},
    // high below low
    '{ROW_CFG, sps_pkg::REG_RANGE_LOW, 32'd10, 1'b0, R_NONE},
    '{ROW_CFG, sps_pkg::REG_RANGE_HIGH, 32'd5, 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b1, R_BAD},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_RESTART), 1'b1, R_BAD_RW},
    // span one beyond the segment store
    '{ROW_CFG, sps_pkg::REG_RANGE_LOW, 32'd1, 1'b0, R_NONE},
    '{ROW_CFG, sps_pkg::REG_RANGE_HIGH, 32'd131073, 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b1, R_BAD},
    // span exactly the segment store
    '{ROW_CFG, sps_pkg::REG_RANGE_LOW, 32'd2, 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    // spare indexes leave the cursor alone
    '{ROW_CFG, REG_SPARE_2, 32'hDEADBEEF, 1'b0, R_NONE},
    '{ROW_CFG, REG_SPARE_3, 32'h2150A5C3, 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    // top of the 30-bit range, upper data bits dropped
    '{ROW_CFG, sps_pkg::REG_RANGE_LOW, 32'hFFFFFFC0, 1'b0, R_NONE},
    '{ROW_CFG, sps_pkg::REG_RANGE_HIGH, 32'hFFFFFFFF, 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE},
    '{ROW_REQ, sps_pkg::REG_RANGE_LOW, 32'(REQ_FETCH), 1'b0, R_NONE}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [7:0]                     s_axis_tdata_i = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [31:0]                    m_axis_tdata_o;
  logic                           m_axis_tlast_o;
  logic [1:0]                     m_axis_tuser_o;

  segmented_prime_sieve DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the sieve state and the range registers
  // ---------------------------------------------------------------------------
  bit          base_composite [BASE];
  bit          window_composite [SPAN];
  int unsigned scan_pos;
  bit          window_sieved;
  int unsigned win_low, win_high;

  sps_pkg::res_t primes_due [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned hold_off = 0;   // long receiver stall requested by the stimulus
  bit          no_gaps = 1'b0;

  function automatic void build_base_primes();
    for (int unsigned i = 0; i < BASE; i++) base_composite[i] = 1'b0;
    base_composite[0] = 1'b1;
    base_composite[1] = 1'b1;
    for (int unsigned i = 2; longint'(i) * i < BASE; i++) begin
      if (!base_composite[i]) begin
        for (int unsigned j = i * i; j < BASE; j += i) base_composite[j] = 1'b1;
      end
    end
  endfunction

  function automatic bit window_bad();
    if (win_high < win_low) return 1'b1;
    return (longint'(win_high) - win_low + 1) > SPAN;
  endfunction

  function automatic void sieve_window();
    longint unsigned start;
    longint unsigned lo;
    longint unsigned hi;
    lo = win_low;
    hi = win_high;
    for (int unsigned i = 0; i < SPAN; i++) window_composite[i] = 1'b0;
    for (longint unsigned p = 2; p < BASE && p * p <= hi; p++) begin
      if (!base_composite[p]) begin
        start = ((lo + p - 1) / p) * p;
        if (start < p * p) start = p * p;
        for (longint unsigned j = start; j <= hi; j += p)
          window_composite[(j - lo) & (SPAN - 1)] = 1'b1;
      end
    end
  endfunction

  // offset of the next unmarked number >= 2 at or after off, span when none
  function automatic int unsigned next_unmarked(int unsigned off, int unsigned span);
    while (off < span) begin
      if (!window_composite[off] && (longint'(win_low) + off >= 2)) return off;
      off++;
    end
    return span;
  endfunction

  function automatic sps_pkg::res_t predict_prime(bit restart);
    sps_pkg::res_t r;
    int unsigned   span;
    int unsigned   found;
    int unsigned   after;
    r = '0;
    r.range_error = window_bad();
    if (restart) begin
      scan_pos = 0;
      window_sieved = 1'b0;
      return r;
    end
    if (r.range_error) begin
      r.exhausted = 1'b1;
      return r;
    end
    span = win_high - win_low + 1;
    if (!window_sieved) begin
      sieve_window();
      scan_pos = 0;
      window_sieved = 1'b1;
    end
    found = next_unmarked(scan_pos, span);
    if (found >= span) begin
      scan_pos = span;
      r.exhausted = 1'b1;
      return r;
    end
    scan_pos = found + 1;
    after = next_unmarked(scan_pos, span);
    r.prime_value = sps_pkg::PRIME_W'(win_low + found);
    r.last_prime = (after >= span);
    return r;
  endfunction

  function automatic void apply_range_write(logic [sps_pkg::CFG_IDX_W-1:0] idx,
                                            logic [sps_pkg::CFG_DATA_W-1:0] data);
    if (idx == sps_pkg::REG_RANGE_LOW) win_low = data[sps_pkg::PRIME_W-1:0];
    else if (idx == sps_pkg::REG_RANGE_HIGH) win_high = data[sps_pkg::PRIME_W-1:0];
    else return;
    window_sieved = 1'b0;
    scan_pos = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    sps_pkg::res_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (primes_due.size() == 0) begin
        report_mismatch("unexpected result, value",
                        m_axis_tdata_o[sps_pkg::PRIME_W-1:0], 0);
      end else begin
        want = primes_due.pop_front();
        if (m_axis_tdata_o[sps_pkg::PRIME_W-1:0] !== want.prime_value)
          report_mismatch("prime_value", m_axis_tdata_o[sps_pkg::PRIME_W-1:0],
                          want.prime_value);
        if (m_axis_tlast_o !== want.last_prime)
          report_mismatch("last_prime", m_axis_tlast_o, want.last_prime);
        if (m_axis_tuser_o[0] !== want.exhausted)
          report_mismatch("exhausted", m_axis_tuser_o[0], want.exhausted);
        if (m_axis_tuser_o[1] !== want.range_error)
          report_mismatch("range_error", m_axis_tuser_o[1], want.range_error);
      end
    end
    // count silent cycles on all three channels
    if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("[segmented_prime_sieve] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on demand
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        m_axis_tready_i = 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i = 1'b1;
        if (!no_gaps && ($urandom % 6 == 0))
          stall_left = ($urandom % 10 == 0) ? $urandom_range(20, 90) : $urandom_range(1, 3);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    if (no_gaps || ($urandom % 3 != 0)) return 0;
    return ($urandom % 12 == 0) ? $urandom_range(15, 70) : $urandom_range(1, 3);
  endfunction

  // Offer one request; book its expected result once it is accepted.
  task automatic send_request(bit restart, bit typed, sps_pkg::res_t typed_res);
    int unsigned   gap;
    sps_pkg::res_t predicted;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {7'($urandom), restart};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = predict_prime(restart);
    primes_due.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (primes_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write one register; only called with the block idle.
  task automatic write_range(logic [sps_pkg::CFG_IDX_W-1:0] idx,
                             logic [sps_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_range_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i = 32'($urandom);
  endtask

  task automatic set_random_range();
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    pick = $urandom % 12;
    if (pick == 0) begin
      lo = $urandom_range(1, 1000);
      hi = $urandom_range(0, lo - 1);
    end else if (pick == 1) begin
      lo = $urandom_range(0, 1000);
      hi = lo + SPAN + $urandom_range(0, 1000);
    end else if (pick == 2) begin
      // big numbers, short windows; keep sieving cheap
      lo = $urandom_range(0, 1 << 24);
      hi = lo + $urandom_range(0, 120);
    end else if (pick == 3) begin
      lo = $urandom_range(0, 3);
      hi = lo + $urandom_range(0, 4);
    end else begin
      lo = $urandom_range(0, 5000);
      hi = lo + $urandom_range(0, 300);
    end
    if ($urandom % 2) begin
      write_range(sps_pkg::REG_RANGE_LOW, {2'($urandom), 30'(lo)});
      write_range(sps_pkg::REG_RANGE_HIGH, {2'($urandom), 30'(hi)});
    end else begin
      write_range(sps_pkg::REG_RANGE_HIGH, {2'($urandom), 30'(hi)});
      write_range(sps_pkg::REG_RANGE_LOW, {2'($urandom), 30'(lo)});
    end
    if ($urandom % 8 == 0)
      write_range(($urandom % 2) ? REG_SPARE_2 : REG_SPARE_3, 32'($urandom));
  endtask

  initial begin
    int unsigned phase;
    int unsigned n_fetch;
    win_low = 1;
    win_high = 1;
    scan_pos = 0;
    window_sieved = 1'b0;
    build_base_primes();
    for (int unsigned i = 0; i < SPAN; i++) window_composite[i] = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table; writes wait for the block to drain
    for (int unsigned r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        drain_results();
        write_range(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        send_request(DIRECTED[r].data[0], DIRECTED[r].typed, DIRECTED[r].res);
      end
    end
    drain_results();

    // random phases: new range, then a run of fetches with the odd restart
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      set_random_range();
      no_gaps = ($urandom % 5 == 0);
      n_fetch = $urandom_range(5, 60);
      if (phase == 2) begin
        // hold the receiver off and keep offering, so the block backs up
        no_gaps = 1'b1;
        n_fetch = 40;
        hold_off = 400;
      end
      for (int unsigned k = 0; k < n_fetch; k++)
        send_request(($urandom % 12 == 0) ? REQ_RESTART : REQ_FETCH, 1'b0, R_NONE);
      // pause the sender until every result is back
      drain_results();
      phase++;
    end

    no_gaps = 1'b0;
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[segmented_prime_sieve] OK");
    end else begin
      $display("[segmented_prime_sieve] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
